>>> src/srsg_pkg.sv
`timescale 1ns / 1ps

package srsg_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned VelW  = 16;
  localparam int unsigned MagW  = 15;
  localparam int unsigned InDW  = 56;
  localparam int unsigned OutDW = 56;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_FWD  = 2'd1,
    EV_REV  = 2'd2
  } step_ev_t;

  typedef struct packed {
    op_t                    opcode;
    logic signed [PosW-1:0] target_position;
    logic signed [VelW-1:0] speed;
    logic                   toward_target;
  } item_t;

  typedef struct packed {
    step_ev_t               step_event;
    logic signed [PosW-1:0] position;
    logic signed [VelW-1:0] velocity_now;
  } result_t;

endpackage

>>> src/srsg_motion.sv
`timescale 1ns / 1ps

module srsg_motion (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  srsg_pkg::item_t                  item,
  input  logic [srsg_pkg::MagW-1:0]        accel_magnitude,
  output srsg_pkg::result_t                result
);

  logic signed [srsg_pkg::VelW-1:0] phase;
  logic signed [srsg_pkg::VelW-1:0] velocity;
  logic signed [srsg_pkg::VelW-1:0] acceleration;
  logic signed [srsg_pkg::PosW-1:0] step_count;
  logic signed [srsg_pkg::VelW-1:0] goal_velocity;
  logic signed [srsg_pkg::PosW-1:0] goal_position;

  logic signed [srsg_pkg::VelW-1:0] phase_next;
  logic signed [srsg_pkg::VelW-1:0] velocity_next;
  logic signed [srsg_pkg::VelW-1:0] acceleration_next;
  logic signed [srsg_pkg::PosW-1:0] step_count_next;
  logic signed [srsg_pkg::VelW-1:0] goal_velocity_next;
  logic signed [srsg_pkg::PosW-1:0] goal_position_next;

  logic signed [srsg_pkg::VelW-1:0] gv_tick;
  logic signed [srsg_pkg::VelW-1:0] v_ctl;
  logic signed [srsg_pkg::VelW-1:0] acc_ctl;
  logic signed [srsg_pkg::VelW-1:0] err;
  logic signed [srsg_pkg::VelW-1:0] mag_pos;
  logic signed [srsg_pkg::VelW-1:0] mag_neg;
  logic signed [srsg_pkg::VelW-1:0] nph;
  srsg_pkg::step_ev_t               ev;

  assign mag_pos = $signed({1'b0, accel_magnitude});
  assign mag_neg = -mag_pos;

  always_comb begin
    gv_tick = (goal_position == step_count) ? '0 : goal_velocity;
    err     = gv_tick - velocity;
    if (accel_magnitude == '0) begin
      acc_ctl = '0;
      v_ctl   = gv_tick;
    end else if (err >= mag_pos) begin
      acc_ctl = mag_pos;
      v_ctl   = velocity;
    end else if (err <= mag_neg) begin
      acc_ctl = mag_neg;
      v_ctl   = velocity;
    end else begin
      acc_ctl = '0;
      v_ctl   = gv_tick;
    end
    nph = phase + v_ctl;
    ev  = srsg_pkg::EV_NONE;
    if (v_ctl > 0) begin
      if (nph < phase) ev = srsg_pkg::EV_FWD;
    end else begin
      if (nph > phase) ev = srsg_pkg::EV_REV;
    end
  end

  always_comb begin
    phase_next         = phase;
    velocity_next      = velocity;
    acceleration_next  = acceleration;
    step_count_next    = step_count;
    goal_velocity_next = goal_velocity;
    goal_position_next = goal_position;
    result.step_event  = srsg_pkg::EV_NONE;
    if (item.opcode == srsg_pkg::OP_SET) begin
      goal_position_next = item.target_position;
      if (!item.toward_target || item.target_position > step_count) begin
        goal_velocity_next = item.speed;
      end else if (item.target_position < step_count) begin
        goal_velocity_next = -item.speed;
      end else begin
        goal_velocity_next = '0;
      end
    end else begin
      goal_velocity_next = gv_tick;
      acceleration_next  = acc_ctl;
      phase_next         = nph;
      velocity_next      = v_ctl + acc_ctl;
      result.step_event  = ev;
      case (ev)
        srsg_pkg::EV_FWD: step_count_next = step_count + 1;
        srsg_pkg::EV_REV: step_count_next = step_count - 1;
        default:          step_count_next = step_count;
      endcase
    end
    result.position     = step_count_next;
    result.velocity_now = velocity_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= '0;
      velocity      <= '0;
      acceleration  <= '0;
      step_count    <= '0;
      goal_velocity <= '0;
      goal_position <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      velocity      <= velocity_next;
      acceleration  <= acceleration_next;
      step_count    <= step_count_next;
      goal_velocity <= goal_velocity_next;
      goal_position <= goal_position_next;
    end
  end

endmodule

>>> src/stepper_ramp_step_generator_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// s_axis    in   s_tvalid/s_tready    tuser: opcode; tdata: target, speed, toward flag
// m_axis    out  m_tvalid/m_tready    tdata: step_event, position, velocity_now
// cfg       in   cfg_we (no wait)     cfg_data: accel_magnitude
//
// One word per cycle unless m_tready stalls; input register, then result register.
// The tick update is one pass of 16/32-bit adds and compares between those registers.
// Reset (rst, synchronous) clears the motion state, the magnitude and both valid flags.
// A stalled output holds its word; the input stage keeps taking words while the
// result register is empty or being drained in the same cycle.

module stepper_ramp_step_generator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [srsg_pkg::InDW-1:0]        s_tdata,   // target_position, speed, toward_target
  input  logic                             s_tuser,   // opcode
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [srsg_pkg::OutDW-1:0]       m_tdata,   // step_event, position, velocity_now
  input  logic                             cfg_we,
  input  logic [srsg_pkg::MagW-1:0]        cfg_data
);

  logic                         in_valid;
  srsg_pkg::item_t              in_item;
  logic                         advance;
  logic [srsg_pkg::MagW-1:0]    accel_magnitude;
  srsg_pkg::result_t            result;
  srsg_pkg::result_t            out_word;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_magnitude <= '0;
    end else if (cfg_we) begin
      accel_magnitude <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.opcode          <= srsg_pkg::op_t'(s_tuser);
      in_item.target_position <= s_tdata[31:0];
      in_item.speed           <= s_tdata[47:32];
      in_item.toward_target   <= s_tdata[48];
    end
  end

  srsg_motion u_motion (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .item            (in_item),
    .accel_magnitude (accel_magnitude),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  assign m_tdata = {6'b0, out_word.velocity_now, out_word.position, out_word.step_event};

  a_ev_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'b11))
    else $error("illegal step event code");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output back-pressure");

  a_set_no_step: assert property (@(posedge clk) disable iff (rst)
    (advance && in_item.opcode == srsg_pkg::OP_SET) |=> (m_tdata[1:0] == srsg_pkg::EV_NONE))
    else $error("set-target word produced a step");

endmodule
